// ===== rtl/tcwm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcwm_pkg
// shared constants and types of the three-channel window median unit
// ----------------------------------------------------------------------------
`default_nettype none

package tcwm_pkg;

  localparam int unsigned WINDOW_DEPTH = 7;
  localparam int unsigned MID_POS      = WINDOW_DEPTH / 2;
  localparam int unsigned CH_N         = 3;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned POSE_W       = CH_N * SAMPLE_W;
  localparam int unsigned IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // channel 0 is x, 1 is y, 2 is heading
  typedef logic [CH_N-1:0][SAMPLE_W-1:0] pose_t;

  // control that travels with one compare transfer
  typedef struct packed {
    logic valid;
    logic last_j;
  } scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tcwm_ram.sv =====
// ----------------------------------------------------------------------------
// tcwm_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module tcwm_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 4,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]  rdata_a_o,
  output logic      [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== rtl/tcwm_rank_unit.sv =====
// ----------------------------------------------------------------------------
// tcwm_rank_unit
// shared three-lane signed compare unit with rank counters
// ----------------------------------------------------------------------------
`default_nettype none

module tcwm_rank_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tcwm_pkg::scan_ctl_t ctl_i,
  input  wire tcwm_pkg::pose_t     cand_i,
  input  wire tcwm_pkg::pose_t     elem_i,
  output tcwm_pkg::pose_t          median_o
);
  import tcwm_pkg::*;

  logic [CH_N-1:0][CNT_W-1:0] less_q, less_d;
  logic [CH_N-1:0][CNT_W-1:0] eq_q, eq_d;
  logic [CH_N-1:0]            hit;
  pose_t                      median_q;

  always_comb begin
    less_d = less_q;
    eq_d   = eq_q;
    hit    = '0;
    for (int c = 0; c < CH_N; c++) begin
      if ($signed(elem_i[c]) < $signed(cand_i[c])) begin
        less_d[c] = less_q[c] + CNT_W'(1);
      end
      if (elem_i[c] == cand_i[c]) begin
        eq_d[c] = eq_q[c] + CNT_W'(1);
      end
      // candidate covers the middle rank when less <= mid < less + equal
      hit[c] = (less_d[c] <= CNT_W'(MID_POS)) &&
               ((less_d[c] + eq_d[c]) > CNT_W'(MID_POS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q <= '0;
      eq_q   <= '0;
    end else if (ctl_i.valid) begin
      if (ctl_i.last_j) begin
        less_q <= '0;
        eq_q   <= '0;
      end else begin
        less_q <= less_d;
        eq_q   <= eq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CH_N; c++) begin
      if (ctl_i.valid && ctl_i.last_j && hit[c]) begin
        median_q[c] <= cand_i[c];
      end
    end
  end

  assign median_o = median_q;

endmodule

`default_nettype wire

// ===== rtl/three_channel_window_median_unit.sv =====
// ----------------------------------------------------------------------------
// three_channel_window_median_unit
// sliding window median of x, y and heading over the last pose measurements
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | tdata fields (low bit up)
//  s_axis   | in  | s_axis_tvalid/tready   | pos_x[15:0] pos_y[31:16] heading[47:32]
//  m_axis   | out | m_axis_tvalid/tready   | median_x median_y median_heading
//
//  a single compare unit walks every candidate against every entry, reading
//  the window ram through its two registered ports.
//  reset clears the entry valid bits, so unwritten entries read as zero.
//  the input is not ready while an item is in work; a result waiting on
//  m_axis stalls only the final load of the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module three_channel_window_median_unit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [tcwm_pkg::POSE_W-1:0] s_axis_tdata,  // pos_x, pos_y, heading
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [tcwm_pkg::POSE_W-1:0]  m_axis_tdata   // median_x, median_y, median_heading
);
  import tcwm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        slot_q, slot_d;
  logic [IDX_W-1:0]        i_q, i_d;
  logic [IDX_W-1:0]        j_q, j_d;
  logic [WINDOW_DEPTH-1:0] valid_q;
  logic                    va_q, vb_q;
  scan_ctl_t               ctl_q;
  logic                    out_valid_q;
  pose_t                   out_q;

  logic  s_xfer;
  logic  i_last, j_last;
  logic  out_load;
  pose_t rd_a, rd_b, cand, elem, median;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign i_last        = (i_q == IDX_W'(WINDOW_DEPTH - 1));
  assign j_last        = (j_q == IDX_W'(WINDOW_DEPTH - 1));
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  tcwm_ram #(
    .WIDTH (POSE_W),
    .DEPTH (WINDOW_DEPTH),
    .ADDR_W(IDX_W)
  ) u_window (
    .clk_i    (clk_i),
    .we_i     (s_xfer),
    .waddr_i  (slot_q),
    .wdata_i  (s_axis_tdata),
    .raddr_a_i(i_q),
    .raddr_b_i(j_q),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  // entries never written since reset count as zero
  assign cand = va_q ? rd_a : '0;
  assign elem = vb_q ? rd_b : '0;

  tcwm_rank_unit u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_q),
    .cand_i  (cand),
    .elem_i  (elem),
    .median_o(median)
  );

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    i_d     = i_q;
    j_d     = j_q;
    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          slot_d  = (slot_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);
          i_d     = '0;
          j_d     = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            state_d = ST_DRAIN;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      valid_q     <= '0;
      ctl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_q       <= slot_d;
      i_q          <= i_d;
      j_q          <= j_d;
      ctl_q.valid  <= (state_q == ST_SCAN);
      ctl_q.last_j <= j_last;
      if (s_xfer) begin
        valid_q[slot_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    va_q <= valid_q[i_q];
    vb_q <= valid_q[j_q];
    if (out_load) begin
      out_q <= median;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // a transfer starts the sweep at the first candidate and entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> (state_q == ST_SCAN) && (i_q == '0) && (j_q == '0))
    else $error("sweep did not start after input transfer");

  // the written slot is marked valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> valid_q[$past(slot_q)])
    else $error("written window entry not marked valid");

  // no compare is in flight while the input is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && ctl_q.valid))
    else $error("compare in flight while ready for input");

  // a loaded result is offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid && (state_q == ST_IDLE))
    else $error("result load did not present output");

endmodule

`default_nettype wire

// ===== tb/tb_three_channel_window_median_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_channel_window_median_unit
// self-checking bench for the sliding window median of x, y and heading
// ----------------------------------------------------------------------------
// pose transfers go in on s_axis and a scoreboard keeps its own copy of the
// three windows. Each accepted pose yields one predicted median triple, which
// is then compared field by field with the next m_axis transfer. A short
// directed sequence covers extremes, ties and slot wrap. Random drifting
// tracks with outliers and noise follow. Both sides idle at random, with
// one stretch that has no idling.
// ----------------------------------------------------------------------------

module tb_three_channel_window_median_unit;
  import tcwm_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam int unsigned RANDOM_POSES = 880;
  localparam int unsigned ITEM_CYCLES  = WINDOW_DEPTH * WINDOW_DEPTH + 2;

  // keeps the three windows and the queue of medians still owed by the block
  class pose_median_scoreboard;
    sample_t     window_q [CH_N][WINDOW_DEPTH];
    int unsigned oldest_slot;
    pose_t       median_q [$];
    int          fail_count;
    string       field_name [CH_N];

    function new();
      for (int ch = 0; ch < CH_N; ch++) begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
          window_q[ch][i] = '0;
        end
      end
      oldest_slot   = 0;
      fail_count    = 0;
      field_name[0] = "median_x";
      field_name[1] = "median_y";
      field_name[2] = "median_heading";
    endfunction

    // insertion sort by signed value, then pick the middle position
    function sample_t channel_median(int ch);
      sample_t sorted [WINDOW_DEPTH];
      sample_t key;
      int      j;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        sorted[i] = window_q[ch][i];
      end
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        key = sorted[i];
        j   = i - 1;
        while (j >= 0 && sorted[j] > key) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = key;
      end
      return sorted[MID_POS];
    endfunction

    function void note_pose(pose_t pose);
      pose_t medians;
      for (int ch = 0; ch < CH_N; ch++) begin
        window_q[ch][oldest_slot] = sample_t'(pose[ch]);
      end
      oldest_slot = (oldest_slot + 1 == WINDOW_DEPTH) ? 0 : oldest_slot + 1;
      for (int ch = 0; ch < CH_N; ch++) begin
        medians[ch] = channel_median(ch);
      end
      median_q.push_back(medians);
    endfunction

    function void check_medians(pose_t got);
      pose_t want;
      if (median_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result transfer: %h", got);
        end
        return;
      end
      want = median_q.pop_front();
      for (int ch = 0; ch < CH_N; ch++) begin
        if (got[ch] !== want[ch]) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", field_name[ch],
                     $signed(want[ch]), $signed(got[ch]));
          end
        end
      end
    endfunction

    function int unsigned owed();
      return median_q.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [POSE_W-1:0]   s_axis_tdata  = '0;  // pos_x, pos_y, heading
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [POSE_W-1:0]   m_axis_tdata;        // median_x, median_y, median_heading

  pose_median_scoreboard scoreboard;
  bit                    no_idle = 1'b0;
  pose_t                 track;

  three_channel_window_median_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic pose_t make_pose(logic [15:0] x, logic [15:0] y, logic [15:0] h);
    pose_t pose;
    pose[0] = x;
    pose[1] = y;
    pose[2] = h;
    return pose;
  endfunction

  // mostly a drifting track with small noise, plus outliers and extremes
  function automatic pose_t random_pose();
    pose_t       pose;
    int unsigned kind;
    logic [15:0] extremes [5];
    extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    for (int ch = 0; ch < CH_N; ch++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        track[ch] = track[ch] + 16'($signed($urandom_range(0, 64)) - 32);
        pose[ch]  = track[ch] + 16'($signed($urandom_range(0, 8)) - 4);
      end else if (kind == 6) begin
        pose[ch] = track[ch];
      end else if (kind == 7) begin
        pose[ch] = extremes[$urandom_range(0, 4)];
      end else begin
        pose[ch] = 16'($urandom);
        if (kind == 9) begin
          track[ch] = pose[ch];
        end
      end
    end
    return pose;
  endfunction

  task automatic send_pose(pose_t pose);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pose;
    do @(posedge clk_i); while (!s_axis_tready);
    scoreboard.note_pose(pose);
  endtask

  task automatic wait_all_medians();
    while (scoreboard.owed() != 0) @(posedge clk_i);
  endtask

  // result side: random stall before each transfer
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      scoreboard.check_medians(m_axis_tdata);
    end
  end

  initial begin
    pose_t directed_q [$];
    scoreboard = new();
    track      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window still partly zero from reset
    directed_q.push_back(make_pose(16'h0001, 16'hFFFF, 16'h7FFF));
    directed_q.push_back(make_pose(16'h8000, 16'h7FFF, 16'h8000));
    directed_q.push_back(make_pose(16'h7FFF, 16'h8000, 16'hFFFF));
    directed_q.push_back(make_pose(16'hFFFF, 16'h0001, 16'h0000));
    // equal values fill the window, ties and slot wrap
    repeat (8) directed_q.push_back(make_pose(16'h0123, 16'hFEDC, 16'h0123));
    // alternating extremes over a full window
    for (int i = 0; i < 8; i++) begin
      directed_q.push_back(i[0] ? make_pose(16'h7FFF, 16'h8000, 16'h5555)
                                : make_pose(16'h8000, 16'h7FFF, 16'hAAAA));
    end
    foreach (directed_q[i]) send_pose(directed_q[i]);

    // hold off until the block has drained
    s_axis_tvalid <= 1'b0;
    wait_all_medians();
    @(posedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      no_idle = (phase == 1);
      for (int i = 0; i < RANDOM_POSES / 4; i++) begin
        send_pose(random_pose());
      end
      s_axis_tvalid <= 1'b0;
      wait_all_medians();
      @(posedge clk_i);
    end

    no_idle = 1'b0;
    repeat (ITEM_CYCLES + 8) @(posedge clk_i);
    if (scoreboard.fail_count == 0 && scoreboard.owed() == 0) begin
      $display("three_channel_window_median_unit verification clean");
    end else begin
      $display("three_channel_window_median_unit verification failed");
    end
    $finish;
  end

  // slowest correct run is well under 1 ms
  initial begin
    #5_000_000;
    $display("three_channel_window_median_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcwm_pkg.sv
rtl/tcwm_ram.sv
rtl/tcwm_rank_unit.sv
rtl/three_channel_window_median_unit.sv
tb/tb_three_channel_window_median_unit.sv
